@@ rtl/lbvs_pkg.sv @@
package lbvs_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XF,
        ST_WMUL,
        ST_WADD,
        ST_DLOAD,
        ST_DITER,
        ST_DFIN,
        ST_OUT
    } t_state;

    localparam logic CMD_WRITE     = 1'b0;
    localparam logic CMD_INFLUENCE = 1'b1;

    localparam logic [1:0] CFG_JOINT_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROOT_JOINT  = 2'd1;

    localparam logic [8:0] JOINT_COUNT_RST = 9'd256;
    localparam logic [3:0] ELEMENTS        = 4'd12;

endpackage

@@ rtl/linear_blend_vertex_skinning.sv @@
// Linear blend skinning engine.
// The slave stream carries two kinds of request, chosen by tuser: a palette
// write stores one Q16.16 element of a joint's 4x3 matrix, and an influence
// carries a rest vertex, a joint and a Q1.15 weight. tlast marks the final
// influence of a vertex, and only that request produces one result on the
// master stream: the blended, saturated vertex and an overflow flag in tuser.
// The configuration channel (index, data, valid/ready) sets the joint count
// and the root joint; it is always ready. The user must write it only while
// idle; the block itself does not enforce this. A palette write is stored
// without leaving the idle state. An influence that counts makes twelve palette
// reads through the single read port of the palette memory, pipelined through
// one 32x32 multiplier, then three weighted multiply-accumulates. Closing a
// vertex adds three 64-step restoring divisions; a vertex without weight
// instead takes a rigid transform by the root joint.
// A finished result sits in the output register while the block goes on to
// accept the next request; if the receiver still stalls when the following
// result is ready, the block holds in its output state until the register
// frees. Reset clears the sums, the configuration and the control state; the
// palette memory is not cleared and must be written before it is used.
module linear_blend_vertex_skinning #(
    parameter int MAX_JOINTS = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // joint, element, matrix_value, pos_x, pos_y, pos_z, weight, zero pad
    input  logic [159:0] s_axis_tdata,
    // cmd
    input  logic [0:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // skinned_x, skinned_y, skinned_z
    output logic [95:0]  m_axis_tdata,
    // overflow
    output logic [0:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [8:0]   i_cfg_data
);

    localparam int DEPTH = MAX_JOINTS * 12;
    localparam int AW    = $clog2(DEPTH);

    // Request fields.
    logic        in_cmd;
    logic [7:0]  in_joint;
    logic [3:0]  in_elem;
    logic [31:0] in_mval;
    logic [15:0] in_weight;
    logic        in_acc;

    assign in_cmd    = s_axis_tuser[0];
    assign in_joint  = s_axis_tdata[7:0];
    assign in_elem   = s_axis_tdata[11:8];
    assign in_mval   = s_axis_tdata[43:12];
    assign in_weight = s_axis_tdata[155:140];
    assign in_acc    = s_axis_tvalid && s_axis_tready;

    lbvs_pkg::t_state r_state, n_state;

    logic [8:0]  r_joint_count;
    logic [7:0]  r_root;
    logic [31:0] r_p [3];
    logic [15:0] r_w;
    logic        r_last;
    logic [7:0]  r_jsel;
    logic        r_rigid;
    logic [3:0]  r_step;
    logic [1:0]  r_c;
    logic [5:0]  r_cnt;

    logic [31:0]        r_pal [DEPTH];
    logic [31:0]        r_rd;
    logic signed [49:0] r_term;
    logic signed [49:0] r_acc;
    logic [31:0]        r_res [3];
    logic               r_tov;

    logic signed [48:0] r_wprod;
    logic [63:0]        r_sum [3];
    logic [23:0]        r_wt;
    logic               r_sov;

    logic [63:0] r_dvd;
    logic [24:0] r_rem;
    logic        r_neg;

    logic        r_out_valid;
    logic [95:0] r_out_data;
    logic        r_out_ov;

    // Influence and root qualification.
    logic infl_ok, root_ok, pal_we;
    logic [7:0] root_sel;

    assign infl_ok = (32'(in_joint) < 32'(MAX_JOINTS)) && ({1'b0, in_joint} < r_joint_count)
                     && (in_weight != 16'd0);
    assign root_ok = (32'(r_root) < 32'(MAX_JOINTS)) && ({1'b0, r_root} < r_joint_count);
    assign root_sel = root_ok ? r_root : 8'd0;
    assign pal_we = in_acc && (in_cmd == lbvs_pkg::CMD_WRITE)
                    && (in_elem < lbvs_pkg::ELEMENTS) && (32'(in_joint) < 32'(MAX_JOINTS));

    // Palette read schedule: per coordinate the translation first, then rows 0..2.
    logic [1:0]    s_c, s_j;
    logic [3:0]    rd_off;
    logic [AW-1:0] rd_addr, wr_addr;

    assign s_c = r_step[3:2];
    assign s_j = r_step[1:0];
    always_comb begin
        if (s_j == 2'd0) begin
            rd_off = 4'd9 + {2'b0, s_c};
        end else begin
            rd_off = 4'({s_j - 2'd1, 1'b0}) + {2'b0, s_j - 2'd1} + {2'b0, s_c};
        end
    end
    assign rd_addr = AW'(r_jsel) * AW'(12) + AW'(rd_off);
    assign wr_addr = AW'(in_joint) * AW'(12) + AW'(in_elem);

    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            r_pal[wr_addr] <= in_mval;
        end
        r_rd <= r_pal[rd_addr];
    end

    // Term stage and accumulate stage of the transform pipeline.
    logic [3:0]         e1, e2;
    logic signed [63:0] mprod;
    logic signed [49:0] term_n, acc_sum;
    logic               acc_ovf;
    logic [31:0]        acc_sat;

    assign e1 = r_step - 4'd1;
    assign e2 = r_step - 4'd2;
    assign mprod = $signed(r_p[e1[1:0] - 2'd1]) * $signed(r_rd);
    assign term_n = (e1[1:0] == 2'd0) ? 50'($signed(r_rd)) : 50'(mprod >>> 16);
    assign acc_sum = (e2[1:0] == 2'd0) ? r_term : r_acc + r_term;

    always_comb begin
        acc_ovf = 1'b1;
        if (acc_sum > 50'sd2147483647) begin
            acc_sat = 32'h7FFF_FFFF;
        end else if (acc_sum < -50'sd2147483648) begin
            acc_sat = 32'h8000_0000;
        end else begin
            acc_sat = acc_sum[31:0];
            acc_ovf = 1'b0;
        end
    end

    // Weighted accumulate.
    logic signed [64:0] wsum;
    logic [24:0]        wt_sum;

    assign wsum = 65'($signed(r_sum[r_c])) + 65'(r_wprod);
    assign wt_sum = {1'b0, r_wt} + 25'(r_w);

    // Division step and final saturation.
    logic [24:0] trial;
    logic        qbit;
    logic [31:0] q_sat;
    logic        q_ovf;

    assign trial = {r_rem[23:0], r_dvd[63]};
    assign qbit = trial >= {1'b0, r_wt};

    always_comb begin
        q_ovf = 1'b1;
        if (r_neg) begin
            if (r_dvd > 64'h8000_0000) begin
                q_sat = 32'h8000_0000;
            end else begin
                q_sat = 32'h0 - r_dvd[31:0];
                q_ovf = 1'b0;
            end
        end else begin
            if (r_dvd > 64'h7FFF_FFFF) begin
                q_sat = 32'h7FFF_FFFF;
            end else begin
                q_sat = r_dvd[31:0];
                q_ovf = 1'b0;
            end
        end
    end

    logic out_free;
    assign out_free = !r_out_valid || m_axis_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lbvs_pkg::ST_IDLE: begin
                if (in_acc && (in_cmd == lbvs_pkg::CMD_INFLUENCE)) begin
                    if (infl_ok) begin
                        n_state = lbvs_pkg::ST_XF;
                    end else if (s_axis_tlast) begin
                        n_state = (r_wt != 24'd0) ? lbvs_pkg::ST_DLOAD : lbvs_pkg::ST_XF;
                    end
                end
            end
            lbvs_pkg::ST_XF: begin
                if (r_step == 4'd13) begin
                    n_state = r_rigid ? lbvs_pkg::ST_OUT : lbvs_pkg::ST_WMUL;
                end
            end
            lbvs_pkg::ST_WMUL: n_state = lbvs_pkg::ST_WADD;
            lbvs_pkg::ST_WADD: begin
                if (r_c != 2'd2) begin
                    n_state = lbvs_pkg::ST_WMUL;
                end else begin
                    n_state = r_last ? lbvs_pkg::ST_DLOAD : lbvs_pkg::ST_IDLE;
                end
            end
            lbvs_pkg::ST_DLOAD: n_state = lbvs_pkg::ST_DITER;
            lbvs_pkg::ST_DITER: begin
                if (r_cnt == 6'd63) begin
                    n_state = lbvs_pkg::ST_DFIN;
                end
            end
            lbvs_pkg::ST_DFIN: begin
                n_state = (r_c == 2'd2) ? lbvs_pkg::ST_OUT : lbvs_pkg::ST_DLOAD;
            end
            lbvs_pkg::ST_OUT: begin
                if (out_free) begin
                    n_state = lbvs_pkg::ST_IDLE;
                end
            end
            default: n_state = lbvs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbvs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joint_count <= lbvs_pkg::JOINT_COUNT_RST;
            r_root        <= 8'd0;
            r_wt          <= 24'd0;
            r_sov         <= 1'b0;
            r_tov         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_step        <= 4'd0;
            r_c           <= 2'd0;
            r_cnt         <= 6'd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lbvs_pkg::CFG_JOINT_COUNT: r_joint_count <= i_cfg_data;
                    lbvs_pkg::CFG_ROOT_JOINT:  r_root <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // A new result takes the register as the previous one leaves it.
            if (r_state == lbvs_pkg::ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                lbvs_pkg::ST_IDLE: begin
                    r_step <= 4'd0;
                    r_c    <= 2'd0;
                    if (in_acc) begin
                        r_tov <= 1'b0;
                    end
                end
                lbvs_pkg::ST_XF: begin
                    r_step <= r_step + 4'd1;
                    if (r_step >= 4'd2 && e2[1:0] == 2'd3 && acc_ovf) begin
                        r_tov <= 1'b1;
                    end
                end
                lbvs_pkg::ST_WADD: begin
                    if ((wsum[64] != wsum[63])
                        || (r_c == 2'd2 && (r_tov || wt_sum[24]))) begin
                        r_sov <= 1'b1;
                    end
                    if (r_c == 2'd2) begin
                        r_c  <= 2'd0;
                        r_wt <= wt_sum[24] ? 24'hFF_FFFF : wt_sum[23:0];
                    end else begin
                        r_c <= r_c + 2'd1;
                    end
                end
                lbvs_pkg::ST_DLOAD: r_cnt <= 6'd0;
                lbvs_pkg::ST_DITER: r_cnt <= r_cnt + 6'd1;
                lbvs_pkg::ST_DFIN: begin
                    r_c <= r_c + 2'd1;
                    if (q_ovf) begin
                        r_tov <= 1'b1;
                    end
                end
                lbvs_pkg::ST_OUT: begin
                    if (out_free) begin
                        r_wt  <= 24'd0;
                        r_sov <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Running sums: cleared by reset and once a result has been loaded into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_state == lbvs_pkg::ST_OUT && out_free)) begin
            r_sum[0] <= 64'd0;
            r_sum[1] <= 64'd0;
            r_sum[2] <= 64'd0;
        end else if (r_state == lbvs_pkg::ST_WADD) begin
            if (wsum[64] != wsum[63]) begin
                r_sum[r_c] <= wsum[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            end else begin
                r_sum[r_c] <= wsum[63:0];
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == lbvs_pkg::ST_IDLE && in_acc) begin
            r_p[0]  <= s_axis_tdata[75:44];
            r_p[1]  <= s_axis_tdata[107:76];
            r_p[2]  <= s_axis_tdata[139:108];
            r_w     <= in_weight;
            r_last  <= s_axis_tlast;
            r_rigid <= !infl_ok;
            r_jsel  <= infl_ok ? in_joint : root_sel;
        end
        if (r_state == lbvs_pkg::ST_XF) begin
            r_term <= term_n;
            r_acc  <= acc_sum;
            if (r_step >= 4'd2 && e2[1:0] == 2'd3) begin
                r_res[e2[3:2]] <= acc_sat;
            end
        end
        if (r_state == lbvs_pkg::ST_WMUL) begin
            r_wprod <= $signed(r_res[r_c]) * $signed({1'b0, r_w});
        end
        if (r_state == lbvs_pkg::ST_DLOAD) begin
            r_neg <= r_sum[r_c][63];
            r_dvd <= r_sum[r_c][63] ? 64'h0 - r_sum[r_c] : r_sum[r_c];
            r_rem <= 25'd0;
        end
        if (r_state == lbvs_pkg::ST_DITER) begin
            r_rem <= qbit ? trial - {1'b0, r_wt} : trial;
            r_dvd <= {r_dvd[62:0], qbit};
        end
        if (r_state == lbvs_pkg::ST_DFIN) begin
            r_res[r_c] <= q_sat;
        end
        if (r_state == lbvs_pkg::ST_OUT && out_free) begin
            r_out_data <= {r_res[2], r_res[1], r_res[0]};
            r_out_ov   <= r_sov || r_tov;
        end
    end

    assign s_axis_tready   = (r_state == lbvs_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_ov;

    // Division only runs with a nonzero total weight.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbvs_pkg::ST_DITER) |-> (r_wt != 24'd0))
        else $error("division started with zero total weight");

    // A result appears only out of the output state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> ($past(r_state) == lbvs_pkg::ST_OUT))
        else $error("result raised outside the output state");

    // A palette write keeps the block idle.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_cmd == lbvs_pkg::CMD_WRITE) |=> (r_state == lbvs_pkg::ST_IDLE))
        else $error("palette write left the idle state");

    // Transform step counter stays within its schedule.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbvs_pkg::ST_XF) |-> (r_step <= 4'd13))
        else $error("transform step out of range");

endmodule
